[rtl/core/stack_language_lexer_macros.svh]
// Assertion macros for the stack-language lexer
`ifndef STACK_LANGUAGE_LEXER_MACROS_SVH
`define STACK_LANGUAGE_LEXER_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define SLX_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer assertion failed");

// Check that cons holds in the cycle after ante
`define SLX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer assertion failed");

`endif

[rtl/core/slx_pkg.sv]
// Shared types and constants of the stack-language lexer
package slx_pkg;

  // Name buffer size; one slot is reserved, and a name length never exceeds 31
  localparam int NAME_BUFFER_BYTES = 32;
  localparam int KEEP_RAW = NAME_BUFFER_BYTES - 1;
  localparam int KEEP_MAX = (KEEP_RAW < 31) ? KEEP_RAW : 31;

  // Saturation limit of a number token
  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  // Result queue: depth is a power of two so pointers wrap naturally
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  // Special characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  typedef enum logic [2:0] {
    TK_OPEN     = 3'd0,
    TK_CLOSE    = 3'd1,
    TK_NUMBER   = 3'd2,
    TK_BYTE     = 3'd3,
    TK_NAME_END = 3'd4,
    TK_END      = 3'd5,
    TK_BAD      = 3'd6
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [30:0] num;
    logic [7:0]  name_byte;
    logic        lit;
    logic [4:0]  len;
    logic        ovf;
    logic        last;
  } res_t;

  // Up to two result words caused by one input word
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } lex_out_t;

  typedef struct packed {
    logic [RQ_CNT_W-1:0] count;
    logic                room2;
  } rq_stat_t;

endpackage

[rtl/core/slx_if.sv]
// Valid/ready channel interfaces of the lexer

interface slx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_stream;

  modport source(output valid, output char_in, output end_of_stream, input ready);
  modport sink(input valid, input char_in, input end_of_stream, output ready);
endinterface

interface slx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [30:0] number_value;
  logic [7:0]  name_byte;
  logic        is_literal;
  logic [4:0]  name_len;
  logic        overflowed;
  logic        last_result;

  modport source(output valid, output token_kind, output number_value, output name_byte,
                 output is_literal, output name_len, output overflowed,
                 output last_result, input ready);
  modport sink(input valid, input token_kind, input number_value, input name_byte,
               input is_literal, input name_len, input overflowed,
               input last_result, output ready);
endinterface

[rtl/core/stack_language_lexer.sv]
// Path: an accepted word is held in the input stage register and is lexed when it advances;
// its result words then enter the queue (out valid while it holds any), first word first.
// Throughput: one input word per cycle while each word gives at most one result and the
// output takes results; words that give two results drain at one result per cycle through a 4-entry queue.
// Reset (rst_n low, synchronous): lexer idle between tokens, stage and queue empty.
module stack_language_lexer (
  input  logic     clk,
  input  logic     rst_n,
  slx_in_if.sink   in_chan,
  slx_out_if.source out_chan
);

  `include "stack_language_lexer_macros.svh"

  logic              stg_v_r;
  logic [7:0]        stg_char_r;
  logic              stg_eos_r;
  logic              adv;
  logic              pop;
  logic              pair_closes;
  slx_pkg::lex_out_t lo;
  slx_pkg::res_t     head;
  slx_pkg::rq_stat_t rq_stat;

  // Advance the staged word when the queue can take two results
  assign adv           = stg_v_r && rq_stat.room2;
  assign in_chan.ready = !stg_v_r || adv;
  assign pop           = out_chan.valid && out_chan.ready;

  // Input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      stg_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      stg_char_r <= in_chan.char_in;
      stg_eos_r  <= in_chan.end_of_stream;
    end
  end

  slx_lex u_lex (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .c     (stg_char_r),
    .eos   (stg_eos_r),
    .lo    (lo)
  );

  slx_rfifo u_rq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (adv ? lo.n : 2'd0),
    .d0     (lo.r0),
    .d1     (lo.r1),
    .pop    (pop),
    .head   (head),
    .stat   (rq_stat)
  );

  // Drive the result channel from the queue head
  assign out_chan.valid        = (rq_stat.count != '0);
  assign out_chan.token_kind   = head.kind;
  assign out_chan.number_value = head.num;
  assign out_chan.name_byte    = head.name_byte;
  assign out_chan.is_literal   = head.lit;
  assign out_chan.name_len     = head.len;
  assign out_chan.overflowed   = head.ovf;
  assign out_chan.last_result  = head.last;

  // First result word closes a name or a number
  assign pair_closes = (lo.r0.kind == slx_pkg::TK_NAME_END) ||
                       (lo.r0.kind == slx_pkg::TK_NUMBER);

  // End of stream always yields at least the end word
  `SLX_ASSERT_SAME(a_eos_result, clk, rst_n, adv && stg_eos_r, lo.n != 2'd0)
  // A pair of results always opens with a closed token
  `SLX_ASSERT_SAME(a_pair_head, clk, rst_n, adv && (lo.n == 2'd2), pair_closes)
  // The rest of an item's results is already queued
  `SLX_ASSERT_NEXT(a_pair_tail, clk, rst_n, pop && !out_chan.last_result, out_chan.valid)
  // Queue never overfills
  `SLX_ASSERT_SAME(a_rq_bound, clk, rst_n, 1'b1, rq_stat.count <= slx_pkg::RQ_CNT_W'(slx_pkg::RQ_DEPTH))

endmodule

[rtl/core/slx_lex.sv]
// Lexer mode register and per-word token logic
module slx_lex (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [7:0]          c,
  input  logic                eos,
  output slx_pkg::lex_out_t   lo
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_LIT,
    M_NUM,
    M_NAME,
    M_HALT
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;

  logic is_dig, is_alnum, is_graph;

  // Idle-path outcome
  logic          idl_v;
  slx_pkg::res_t idl_res;
  mode_t         idl_mode;
  logic [30:0]   idl_acc;
  logic [4:0]    idl_cnt;

  // Token-end result, then byte or idle result
  logic          a_v, b_v;
  slx_pkg::res_t a_res, b_res;
  logic [34:0]   acc_sum;

  // Classify the byte
  assign is_dig   = c inside {[8'h30:8'h39]};
  assign is_alnum = is_dig || (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
  assign is_graph = c inside {[8'h21:8'h7E]};

  assign acc_sum = 35'({acc_r, 3'b000}) + 35'({acc_r, 1'b0}) + 35'(c[3:0]);

  // Treat the byte as if between tokens
  always_comb begin
    idl_v    = 1'b0;
    idl_res  = '0;
    idl_mode = M_IDLE;
    idl_acc  = '0;
    idl_cnt  = '0;
    if (c == slx_pkg::CH_SPACE) begin
      idl_v = 1'b0;
    end else if (c == slx_pkg::CH_LBRACE) begin
      idl_v        = 1'b1;
      idl_res.kind = slx_pkg::TK_OPEN;
    end else if (c == slx_pkg::CH_RBRACE) begin
      idl_v        = 1'b1;
      idl_res.kind = slx_pkg::TK_CLOSE;
    end else if (c == slx_pkg::CH_SLASH) begin
      idl_mode = M_LIT;
    end else if (is_dig) begin
      idl_mode = M_NUM;
      idl_acc  = 31'(c[3:0]);
    end else if (is_graph) begin
      // Buffer always has room for the first byte
      idl_mode          = M_NAME;
      idl_v             = 1'b1;
      idl_res.kind      = slx_pkg::TK_BYTE;
      idl_res.name_byte = c;
      idl_cnt           = 5'd1;
    end else begin
      idl_mode     = M_HALT;
      idl_v        = 1'b1;
      idl_res.kind = slx_pkg::TK_BAD;
    end
  end

  // Mode update and result selection
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    a_v      = 1'b0;
    a_res    = '0;
    b_v      = 1'b0;
    b_res    = '0;
    if (eos) begin
      case (mode_r)
        M_LIT, M_NAME: begin
          a_v        = 1'b1;
          a_res.kind = slx_pkg::TK_NAME_END;
          a_res.lit  = (mode_r == M_LIT);
          a_res.len  = cnt_r;
          a_res.ovf  = ovf_r;
        end
        M_NUM: begin
          a_v        = 1'b1;
          a_res.kind = slx_pkg::TK_NUMBER;
          a_res.num  = acc_r;
          a_res.ovf  = ovf_r;
        end
        default: a_v = 1'b0;
      endcase
      b_v        = 1'b1;
      b_res.kind = slx_pkg::TK_END;
      mode_nxt   = M_IDLE;
      acc_nxt    = '0;
      cnt_nxt    = '0;
      ovf_nxt    = 1'b0;
    end else begin
      case (mode_r)
        M_HALT: begin
          mode_nxt = M_HALT;
        end
        M_LIT, M_NAME: begin
          if ((mode_r == M_LIT) ? is_alnum : is_graph) begin
            // Keep the byte while the buffer has room, else drop it
            if (cnt_r < 5'(slx_pkg::KEEP_MAX)) begin
              b_v             = 1'b1;
              b_res.kind      = slx_pkg::TK_BYTE;
              b_res.name_byte = c;
              b_res.lit       = (mode_r == M_LIT);
              cnt_nxt         = cnt_r + 5'd1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            a_v        = 1'b1;
            a_res.kind = slx_pkg::TK_NAME_END;
            a_res.lit  = (mode_r == M_LIT);
            a_res.len  = cnt_r;
            a_res.ovf  = ovf_r;
            b_v        = idl_v;
            b_res      = idl_res;
            mode_nxt   = idl_mode;
            acc_nxt    = idl_acc;
            cnt_nxt    = idl_cnt;
            ovf_nxt    = 1'b0;
          end
        end
        M_NUM: begin
          if (is_dig) begin
            // Saturate when ten times the value plus the digit passes the limit
            if (acc_sum > 35'(slx_pkg::NUM_MAX)) begin
              acc_nxt = slx_pkg::NUM_MAX;
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = acc_sum[30:0];
            end
          end else begin
            a_v        = 1'b1;
            a_res.kind = slx_pkg::TK_NUMBER;
            a_res.num  = acc_r;
            a_res.ovf  = ovf_r;
            b_v        = idl_v;
            b_res      = idl_res;
            mode_nxt   = idl_mode;
            acc_nxt    = idl_acc;
            cnt_nxt    = idl_cnt;
            ovf_nxt    = 1'b0;
          end
        end
        default: begin
          b_v      = idl_v;
          b_res    = idl_res;
          mode_nxt = idl_mode;
          acc_nxt  = idl_acc;
          cnt_nxt  = idl_cnt;
          ovf_nxt  = 1'b0;
        end
      endcase
    end
  end

  // Pack results in order and mark the final one
  always_comb begin
    lo = '0;
    if (a_v) begin
      lo.r0 = a_res;
      lo.r1 = b_res;
      lo.n  = b_v ? 2'd2 : 2'd1;
    end else begin
      lo.r0 = b_res;
      lo.n  = b_v ? 2'd1 : 2'd0;
    end
    lo.r0.last = (lo.n == 2'd1);
    lo.r1.last = 1'b1;
  end

  // Hold lexer state, advance on each word taken from the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r  <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

[rtl/core/slx_rfifo.sv]
// Result queue: takes up to two words per cycle, gives one
module slx_rfifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,
  input  slx_pkg::res_t     d0,
  input  slx_pkg::res_t     d1,
  input  logic              pop,
  output slx_pkg::res_t     head,
  output slx_pkg::rq_stat_t stat
);

  slx_pkg::res_t               mem_r [slx_pkg::RQ_DEPTH];
  logic [slx_pkg::RQ_PTR_W-1:0] wr_r, rd_r, wr_p1;
  logic [slx_pkg::RQ_CNT_W-1:0] cnt_r;

  assign wr_p1      = wr_r + 1'b1;
  assign head       = mem_r[rd_r];
  assign stat.count = cnt_r;
  assign stat.room2 = (cnt_r <= slx_pkg::RQ_CNT_W'(slx_pkg::RQ_DEPTH - 2));

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + slx_pkg::RQ_PTR_W'(push_n);
      rd_r  <= rd_r + slx_pkg::RQ_PTR_W'(pop);
      cnt_r <= cnt_r + slx_pkg::RQ_CNT_W'(push_n) - slx_pkg::RQ_CNT_W'(pop);
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= d0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_p1] <= d1;
    end
  end

endmodule
